// ===== rtl/core/bcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bcmf_pkg
// Shared constants and types for the binary cross morphology filter.
// ----------------------------------------------------------------------------
package bcmf_pkg;

  localparam int MAX_WIDTH = 512;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int IMG_W_W   = 10;
  localparam int USED_W    = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
  localparam int MIN_WIDTH = 3;

  localparam logic [7:0]         THRESHOLD_RST = 8'd40;
  localparam logic [1:0]         MODE_RST      = 2'd1;
  localparam logic [IMG_W_W-1:0] IMG_WIDTH_RST = IMG_W_W'(500);

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MODE      = 2'd1,
    REG_IMG_WIDTH = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_ERODE  = 2'd2
  } mode_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    logic pixel_black;
    logic row_last;
    logic frame_last;
  } res_t;

endpackage

// ===== rtl/core/bcmf_ram.sv =====
// ----------------------------------------------------------------------------
// bcmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcmf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/binary_cross_morphology_filter_core.sv =====
// ----------------------------------------------------------------------------
// binary_cross_morphology_filter_core
// Thresholds RGB pixels to binary and applies a 3x3 cross dilate or erode (or
// passes the pixel through), one row behind the input, using three line-store RAMs.
// ----------------------------------------------------------------------------
// Output: each result is registered in the output stage, or in the skid stage
//   while the output is stalled; image output trails input by one row.
// Throughput: one item per clock while in_stall is low (skid stage empty); line
//   stores are prefetched at the next column each cycle so the registered read is ready for the next item.
// Reset: control state cleared, registers load 40 / 1 / 500; line stores
//   are not cleared.
// ----------------------------------------------------------------------------
module binary_cross_morphology_filter_core (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_pixel_black,
  output logic       out_row_last,
  output logic       out_frame_last,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [bcmf_pkg::IMG_W_W-1:0] cfg_data
);

  localparam int COL_W  = bcmf_pkg::COL_W;
  localparam int USED_W = bcmf_pkg::USED_W;

  // configuration registers
  logic [7:0]                   threshold_r;
  logic [1:0]                   mode_r;
  logic [bcmf_pkg::IMG_W_W-1:0] img_width_r;

  // control state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [1:0]       rows_seen_r, rows_seen_nxt;
  logic             draining_r, draining_nxt;
  logic             left_center_r;

  // output and skid stages
  logic            out_valid_r, skid_valid_r;
  bcmf_pkg::res_t  out_data_r, skid_data_r, res;

  // datapath
  logic              accept, ignore, process, start_drain, draining_now;
  logic [9:0]        sum, thr3;
  logic              cur, center, up, right, res_bit, last;
  logic              has_left, has_right, has_up, has_down, has_out, emit;
  logic [USED_W-1:0] img_w_ext, used_w, col_p1;
  logic              store_we;
  logic [COL_W-1:0]  raddr_right;
  logic              out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= bcmf_pkg::THRESHOLD_RST;
      mode_r      <= bcmf_pkg::MODE_RST;
      img_width_r <= bcmf_pkg::IMG_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bcmf_pkg::REG_THRESHOLD: threshold_r <= cfg_data[7:0];
        bcmf_pkg::REG_MODE:      mode_r      <= cfg_data[1:0];
        bcmf_pkg::REG_IMG_WIDTH: img_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate the row width to the supported range
  always_comb begin
    img_w_ext = USED_W'(img_width_r);
    if (img_w_ext < USED_W'(bcmf_pkg::MIN_WIDTH)) begin
      used_w = USED_W'(bcmf_pkg::MIN_WIDTH);
    end else if (img_w_ext > USED_W'(bcmf_pkg::MAX_WIDTH)) begin
      used_w = USED_W'(bcmf_pkg::MAX_WIDTH);
    end else begin
      used_w = img_w_ext;
    end
  end

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ignore = 1'b0;
    if (in_op == bcmf_pkg::OP_PIXEL && draining_r) begin
      ignore = 1'b1;
    end else if (in_op == bcmf_pkg::OP_DRAIN && !draining_r &&
                 (col_r != '0 || rows_seen_r == 2'd0)) begin
      ignore = 1'b1;
    end
  end

  assign process      = accept && !ignore;
  assign start_drain  = (in_op == bcmf_pkg::OP_DRAIN) && !draining_r;
  assign draining_now = draining_r || start_drain;

  // floor(sum/3) < t  is the same as  sum < 3t
  assign sum  = 10'(in_red) + 10'(in_green) + 10'(in_blue);
  assign thr3 = {1'b0, threshold_r, 1'b0} + 10'(threshold_r);
  assign cur  = (sum < thr3);

  assign col_p1    = USED_W'(col_r) + USED_W'(1);
  assign has_left  = (col_r != '0);
  assign has_right = (col_p1 < used_w);
  assign has_up    = (rows_seen_r == 2'd2);
  assign has_down  = !draining_now;
  assign has_out   = draining_now || (rows_seen_r != 2'd0);
  assign last      = !has_right;

  always_comb begin
    res_bit = center;
    case (mode_r)
      bcmf_pkg::MODE_DILATE: begin
        if ((has_left && left_center_r) || (has_right && right) ||
            (has_up && up) || (has_down && cur)) begin
          res_bit = 1'b1;
        end
      end
      bcmf_pkg::MODE_ERODE: begin
        if ((has_left && !left_center_r) || (has_right && !right) ||
            (has_up && !up) || (has_down && !cur)) begin
          res_bit = 1'b0;
        end
      end
      default: res_bit = center;
    endcase
  end

  assign res.pixel_black = res_bit;
  assign res.row_last    = last;
  assign res.frame_last  = last && draining_now;
  assign emit            = process && has_out;

  always_comb begin
    col_nxt       = col_r;
    rows_seen_nxt = rows_seen_r;
    draining_nxt  = draining_r;
    if (process) begin
      draining_nxt = draining_now;
      if (last) begin
        col_nxt = '0;
        if (draining_now) begin
          draining_nxt  = 1'b0;
          rows_seen_nxt = 2'd0;
        end else if (rows_seen_r != 2'd2) begin
          rows_seen_nxt = rows_seen_r + 2'd1;
        end
      end else begin
        col_nxt = col_p1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      rows_seen_r   <= 2'd0;
      draining_r    <= 1'b0;
      left_center_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      rows_seen_r <= rows_seen_nxt;
      draining_r  <= draining_nxt;
      if (process) begin
        left_center_r <= center;
      end
    end
  end

  // line stores: read the column of the next item, write the current one
  assign store_we    = process && !draining_now;
  assign raddr_right = col_nxt + COL_W'(1);

  bcmf_ram #(.WIDTH(1), .DEPTH(bcmf_pkg::MAX_WIDTH)) u_above_center (
    .clk   (clk),
    .we    (store_we),
    .waddr (col_r),
    .wdata (cur),
    .raddr (col_nxt),
    .rdata (center)
  );

  bcmf_ram #(.WIDTH(1), .DEPTH(bcmf_pkg::MAX_WIDTH)) u_above_right (
    .clk   (clk),
    .we    (store_we),
    .waddr (col_r),
    .wdata (cur),
    .raddr (raddr_right),
    .rdata (right)
  );

  bcmf_ram #(.WIDTH(1), .DEPTH(bcmf_pkg::MAX_WIDTH)) u_two_above (
    .clk   (clk),
    .we    (store_we),
    .waddr (col_r),
    .wdata (center),
    .raddr (col_nxt),
    .rdata (up)
  );

  // output register with skid stage
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= emit;
        end
      end else if (emit) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (emit && out_valid_r && !out_take) begin
      skid_data_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_black = out_data_r.pixel_black;
  assign out_row_last    = out_data_r.row_last;
  assign out_frame_last  = out_data_r.frame_last;

  // hold: skid only fills behind a full output stage
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output stage empty");

  a_drain_has_rows: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> rows_seen_r != 2'd0)
    else $error("draining with no stored row");

  a_frame_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (process && last && draining_now) |=> (!draining_r && rows_seen_r == 2'd0
                                           && col_r == '0))
    else $error("frame end did not restart the block");

  a_frame_last_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_last) |-> out_data_r.row_last)
    else $error("frame_last without row_last");

  a_ignored_holds_column: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ignore) |=> $stable(col_r))
    else $error("ignored item moved the column");

endmodule

// ===== verif/bcmf_filter_checker.sv =====
// ----------------------------------------------------------------------------
// bcmf_filter_checker
// Watches the pixel, result and register channels of the cross morphology
// filter, keeps its own line stores and counters, predicts every filtered
// pixel and compares it field by field against the result stream.
// ----------------------------------------------------------------------------
module bcmf_filter_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_op,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_pixel_black,
  input  logic                         out_row_last,
  input  logic                         out_frame_last,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [bcmf_pkg::IMG_W_W-1:0] cfg_data,
  output int                           mismatches,
  output int                           awaiting
);

  logic [7:0]                   thresh;
  logic [1:0]                   filt_mode;
  logic [bcmf_pkg::IMG_W_W-1:0] img_width;

  logic above_row     [bcmf_pkg::MAX_WIDTH];
  logic two_above_row [bcmf_pkg::MAX_WIDTH];
  int   col;
  int   rows_seen;
  bit   draining;
  logic left_px;

  bcmf_pkg::res_t expected_pixels[$];
  bcmf_pkg::res_t oldest;

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  // Advance the filter state by one accepted item and queue its pixel, if any.
  task automatic filter_item(input bcmf_pkg::op_t op, input logic [7:0] r, g, b);
    int   w;
    int   c;
    int   mean;
    logic cur;
    logic center;
    logic up;
    logic right_px;
    logic filt;
    logic last;
    logic frame_end;
    bit   has_up;
    bit   has_left;
    bit   has_right;
    bit   has_down;
    bit   has_out;
    bcmf_pkg::res_t res;
    w = int'(img_width);
    if (w < bcmf_pkg::MIN_WIDTH) w = bcmf_pkg::MIN_WIDTH;
    if (w > bcmf_pkg::MAX_WIDTH) w = bcmf_pkg::MAX_WIDTH;
    c = (col >= bcmf_pkg::MAX_WIDTH) ? bcmf_pkg::MAX_WIDTH - 1 : col;
    if (op == bcmf_pkg::OP_PIXEL && draining) return;
    if (op == bcmf_pkg::OP_DRAIN && !draining) begin
      if (c != 0 || rows_seen == 0) return;
      draining = 1'b1;
    end
    mean      = (int'(r) + int'(g) + int'(b)) / 3;
    cur       = (mean < int'(thresh));
    center    = above_row[c];
    up        = two_above_row[c];
    has_left  = (c != 0);
    has_right = (c + 1 < w);
    right_px  = has_right ? above_row[c + 1] : 1'b0;
    has_up    = (rows_seen >= 2);
    has_down  = !draining;
    has_out   = draining || rows_seen >= 1;

    filt = center;
    if (filt_mode == bcmf_pkg::MODE_DILATE) begin
      if (has_left && left_px) filt = 1'b1;
      if (has_right && right_px) filt = 1'b1;
      if (has_up && up) filt = 1'b1;
      if (has_down && cur) filt = 1'b1;
    end else if (filt_mode == bcmf_pkg::MODE_ERODE) begin
      if (has_left && !left_px) filt = 1'b0;
      if (has_right && !right_px) filt = 1'b0;
      if (has_up && !up) filt = 1'b0;
      if (has_down && !cur) filt = 1'b0;
    end

    if (!draining) begin
      two_above_row[c] = center;
      above_row[c]     = cur;
    end
    left_px = center;

    last      = (c + 1 >= w);
    frame_end = 1'b0;
    if (last) begin
      col = 0;
      if (draining) begin
        frame_end = 1'b1;
        draining  = 1'b0;
        rows_seen = 0;
      end else if (rows_seen < 2) begin
        rows_seen++;
      end
    end else begin
      col = c + 1;
    end

    if (has_out) begin
      res.pixel_black = filt;
      res.row_last    = last;
      res.frame_last  = frame_end;
      expected_pixels.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thresh    = bcmf_pkg::THRESHOLD_RST;
      filt_mode = bcmf_pkg::MODE_RST;
      img_width = bcmf_pkg::IMG_WIDTH_RST;
      col       = 0;
      rows_seen = 0;
      draining  = 1'b0;
      left_px   = 1'b0;
      expected_pixels.delete();
    end else begin
      // pop before push: a result never belongs to the item accepted at this edge
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel, expected none actual black=%0b %s%0b %s%0b",
                   $time, out_pixel_black, "row_last=", out_row_last,
                   "frame_last=", out_frame_last);
        end else begin
          oldest = expected_pixels.pop_front();
          check_field("pixel_black", oldest.pixel_black, out_pixel_black);
          check_field("row_last", oldest.row_last, out_row_last);
          check_field("frame_last", oldest.frame_last, out_frame_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (bcmf_pkg::reg_idx_t'(cfg_index))
          bcmf_pkg::REG_THRESHOLD: thresh    = cfg_data[7:0];
          bcmf_pkg::REG_MODE:      filt_mode = cfg_data[1:0];
          bcmf_pkg::REG_IMG_WIDTH: img_width = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        filter_item(bcmf_pkg::op_t'(in_op), in_red, in_green, in_blue);
      end
    end
    awaiting <= expected_pixels.size();
  end

endmodule

// ===== verif/binary_cross_morphology_filter_core_tb.sv =====
// ----------------------------------------------------------------------------
// binary_cross_morphology_filter_core_tb
// Drives pixel frames, drain rows and register writes into the filter core
// under several idle and stall patterns; a checker alongside predicts and
// compares every filtered pixel.
// ----------------------------------------------------------------------------
module binary_cross_morphology_filter_core_tb;

  localparam int ITEM_TARGET = 1800;
  localparam int STALL_LIMIT = 5000;

  logic                         clk             = 1'b0;
  logic                         rst_n           = 1'b0;
  logic                         in_valid        = 1'b0;
  logic                         in_stall;
  logic                         in_op           = 1'b0;
  logic [7:0]                   in_red          = '0;
  logic [7:0]                   in_green        = '0;
  logic [7:0]                   in_blue         = '0;
  logic                         out_valid;
  logic                         out_stall       = 1'b0;
  logic                         out_pixel_black;
  logic                         out_row_last;
  logic                         out_frame_last;
  logic                         cfg_valid       = 1'b0;
  logic                         cfg_ready;
  logic [1:0]                   cfg_index       = '0;
  logic [bcmf_pkg::IMG_W_W-1:0] cfg_data        = '0;

  int mismatches;
  int awaiting;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;
  // stimulus-side position in the frame, used only to shape the stream
  int trk_col       = 0;
  int trk_width     = 500;

  binary_cross_morphology_filter_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_black (out_pixel_black),
    .out_row_last    (out_row_last),
    .out_frame_last  (out_frame_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  bcmf_filter_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_black (out_pixel_black),
    .out_row_last    (out_row_last),
    .out_frame_last  (out_frame_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .awaiting        (awaiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("binary_cross_morphology_filter_core_tb failed");
      $finish;
    end
  end

  task automatic send_item(input bcmf_pkg::op_t op, input logic [7:0] r, g, b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b);
    send_item(bcmf_pkg::OP_PIXEL, r, g, b);
    items_sent++;
    if (trk_col + 1 >= trk_width) begin
      trk_col = 0;
    end else begin
      trk_col++;
    end
  endtask

  // Mix dark, bright and fully random pixels so both levels show up.
  task automatic send_random_pixel();
    case ($urandom_range(2))
      0: send_pixel(8'($urandom_range(80)), 8'($urandom_range(80)),
                    8'($urandom_range(80)));
      1: send_pixel(8'($urandom_range(170, 255)), 8'($urandom_range(170, 255)),
                    8'($urandom_range(170, 255)));
      default: send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
    endcase
  endtask

  // Item the block must drop.
  task automatic send_noise(input bcmf_pkg::op_t op);
    send_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  task automatic finish_row();
    while (trk_col != 0) send_random_pixel();
  endtask

  task automatic drain_frame(input bit noisy);
    for (int i = 0; i < trk_width; i++) begin
      // pixels inside a drain row are dropped
      if (noisy && i != 0 && $urandom_range(9) == 0) send_noise(bcmf_pkg::OP_PIXEL);
      send_item(bcmf_pkg::OP_DRAIN, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
      items_sent++;
    end
    trk_col = 0;
  endtask

  // Hold off until every predicted pixel is out and the pipe has settled.
  task automatic quiesce();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bcmf_pkg::reg_idx_t idx, input int value,
                           input bit last_write);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[bcmf_pkg::IMG_W_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last_write) cfg_valid <= 1'b0;
    if (idx == bcmf_pkg::REG_IMG_WIDTH) begin
      trk_width = (value < bcmf_pkg::MIN_WIDTH) ? bcmf_pkg::MIN_WIDTH :
                  (value > bcmf_pkg::MAX_WIDTH) ? bcmf_pkg::MAX_WIDTH : value;
    end
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(19))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(50, 200);
    endcase
  endfunction

  initial begin
    int  frame;
    int  rows;
    int  width;
    bit  wide;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Narrowest image (width below range), highest threshold, dilate.
    write_reg(bcmf_pkg::REG_IMG_WIDTH, 0, 1'b0);
    write_reg(bcmf_pkg::REG_THRESHOLD, 255, 1'b0);
    write_reg(bcmf_pkg::REG_MODE, bcmf_pkg::MODE_DILATE, 1'b1);
    send_item(bcmf_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0);        // nothing stored yet: dropped
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd127, 8'd128);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_item(bcmf_pkg::OP_DRAIN, 8'd255, 8'd255, 8'd255);  // mid-row drain: dropped
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd254);
    send_item(bcmf_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0);
    send_item(bcmf_pkg::OP_PIXEL, 8'd0, 8'd0, 8'd0);        // pixel inside drain row: dropped
    send_item(bcmf_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0);
    send_item(bcmf_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0);
    trk_col = 0;

    // Erode; shrink the width in the middle of a row past the current column.
    quiesce();
    write_reg(bcmf_pkg::REG_THRESHOLD, 128, 1'b0);
    write_reg(bcmf_pkg::REG_MODE, bcmf_pkg::MODE_ERODE, 1'b0);
    write_reg(bcmf_pkg::REG_IMG_WIDTH, 6, 1'b1);
    repeat (4) send_random_pixel();
    quiesce();
    write_reg(bcmf_pkg::REG_IMG_WIDTH, 3, 1'b1);
    finish_row();
    repeat (3) send_random_pixel();
    drain_frame(1'b0);

    items_sent = 0;
    frame      = 0;
    while (items_sent < ITEM_TARGET) begin
      case (frame % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      quiesce();
      wide = (frame == 6);
      case ($urandom_range(9))
        0:       width = $urandom_range(2);
        1:       width = $urandom_range(20, 64);
        default: width = $urandom_range(3, 12);
      endcase
      if (wide) width = $urandom_range(bcmf_pkg::MAX_WIDTH, 1023);
      write_reg(bcmf_pkg::REG_THRESHOLD, pick_threshold(), 1'b0);
      write_reg(bcmf_pkg::REG_MODE, $urandom_range(3), 1'b0);
      write_reg(bcmf_pkg::REG_IMG_WIDTH, width, 1'b1);
      if ($urandom_range(3) == 0) send_noise(bcmf_pkg::OP_DRAIN);
      rows = wide ? 1 : $urandom_range(1, 5);
      for (int r = 0; r < rows; r++) begin
        send_random_pixel();
        if ($urandom_range(9) == 0) send_noise(bcmf_pkg::OP_DRAIN);
        if (!wide && $urandom_range(7) == 0) begin
          // change settings inside the frame; the width may only shrink here
          quiesce();
          case ($urandom_range(2))
            0:       write_reg(bcmf_pkg::REG_THRESHOLD, pick_threshold(), 1'b1);
            1:       write_reg(bcmf_pkg::REG_MODE, $urandom_range(3), 1'b1);
            default: write_reg(bcmf_pkg::REG_IMG_WIDTH,
                               $urandom_range(bcmf_pkg::MIN_WIDTH, trk_width), 1'b1);
          endcase
        end
        finish_row();
      end
      drain_frame(1'b1);
      frame++;
    end

    quiesce();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("binary_cross_morphology_filter_core_tb passed");
    end else begin
      $display("binary_cross_morphology_filter_core_tb failed");
    end
    $finish;
  end

endmodule
